FILE: hdl/lss_pkg.sv
// Shared constants and types for the line substring search unit.
package lss_pkg;

    localparam int BYTE_W      = 8;
    localparam int LINE_W      = 32;
    localparam int LEN_W       = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int REG_BYTES   = 16;
    localparam int WORD_BYTES  = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2
    } t_cfg_reg;

    // Result of processing one text byte.
    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] line_number;
    } t_line_res;

endpackage

FILE: hdl/lss_text_if.sv
// Channel that carries one text byte per transfer.
interface lss_text_if
    import lss_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

FILE: hdl/lss_line_if.sv
// Channel that carries one matching line number per transfer.
interface lss_line_if
    import lss_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] line_number;

    modport source (output valid, output line_number, input ready);
    modport sink   (input valid, input line_number, output ready);
endinterface

FILE: hdl/lss_cfg.sv
// Pattern registers and the derived per-position enable and last-byte masks.
module lss_cfg
    import lss_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]               i_cfg_data,
    output logic [PATTERN_MAX-1:0][BYTE_W-1:0]  o_pat_bytes,
    output logic [PATTERN_MAX-1:0]              o_enable,
    output logic [PATTERN_MAX-1:0]              o_last
);

    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_W-1:0]      r_pat_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                REG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                REG_PATTERN_LEN:  r_pat_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Positions beyond the sixteen stored bytes read as NUL, which ends the pattern.
    // A position is in use when it lies below the length and no NUL precedes or is it.
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
        if (i < WORD_BYTES) begin : g_low
            assign o_pat_bytes[i] = r_pat_low[i*BYTE_W +: BYTE_W];
        end else if (i < REG_BYTES) begin : g_high
            assign o_pat_bytes[i] = r_pat_high[(i-WORD_BYTES)*BYTE_W +: BYTE_W];
        end else begin : g_none
            assign o_pat_bytes[i] = NUL_BYTE;
        end

        if (i == 0) begin : g_first
            assign o_enable[i] = (int'(r_pat_len) > i) && (o_pat_bytes[i] != NUL_BYTE);
        end else begin : g_next
            assign o_enable[i] = (int'(r_pat_len) > i) && (o_pat_bytes[i] != NUL_BYTE)
                                 && o_enable[i-1];
        end

        if (i == PATTERN_MAX - 1) begin : g_top
            assign o_last[i] = o_enable[i];
        end else begin : g_mid
            assign o_last[i] = o_enable[i] && !o_enable[i+1];
        end
    end

endmodule

FILE: hdl/lss_core.sv
// Per-line search state and the shift-and update for one text byte.
module lss_core
    import lss_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [BYTE_W-1:0]                   i_byte,
    input  logic [PATTERN_MAX-1:0][BYTE_W-1:0]  i_pat_bytes,
    input  logic [PATTERN_MAX-1:0]              i_enable,
    input  logic [PATTERN_MAX-1:0]              i_last,
    output t_line_res                           o_res
);

    logic [PATTERN_MAX-1:0] r_match;
    logic                   r_found;
    logic                   r_has_bytes;
    logic                   r_nul_seen;
    logic [LINE_W-1:0]      r_count;

    logic [PATTERN_MAX-1:0] n_match;
    logic                   n_found;
    logic                   n_has_bytes;
    logic                   n_nul_seen;
    logic [LINE_W-1:0]      n_count;
    logic                   is_newline;
    logic                   nul_now;
    logic [PATTERN_MAX-1:0] shifted;

    assign is_newline = (i_byte == NEWLINE_BYTE);
    assign nul_now    = r_nul_seen || (i_byte == NUL_BYTE);

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_shift
        if (i == 0) begin : g_first
            assign shifted[i] = i_enable[i] && (i_pat_bytes[i] == i_byte);
        end else begin : g_next
            assign shifted[i] = i_enable[i] && r_match[i-1] && (i_pat_bytes[i] == i_byte);
        end
    end

    always_comb begin
        n_match     = r_match;
        n_found     = r_found;
        n_has_bytes = 1'b1;
        n_nul_seen  = nul_now;
        n_count     = r_count;
        if (is_newline) begin
            n_match     = '0;
            n_found     = 1'b0;
            n_has_bytes = 1'b0;
            n_nul_seen  = 1'b0;
            n_count     = (r_count == '1) ? r_count : r_count + 1'b1;
        end else if (!nul_now) begin
            n_match = shifted;
            n_found = r_found || ((shifted & i_last) != '0);
        end
    end

    // An empty pattern leaves position zero unused and matches any nonempty line.
    assign o_res.hit         = is_newline && r_has_bytes && (r_found || !i_enable[0]);
    assign o_res.line_number = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= '0;
            r_found     <= 1'b0;
            r_has_bytes <= 1'b0;
            r_nul_seen  <= 1'b0;
            r_count     <= '0;
        end else if (i_step) begin
            r_match     <= n_match;
            r_found     <= n_found;
            r_has_bytes <= n_has_bytes;
            r_nul_seen  <= n_nul_seen;
            r_count     <= n_count;
        end
    end

endmodule

FILE: hdl/line_substring_search_unit.sv
// Top level of the line substring search unit: input register, search core, result register.
//
// The unit scans a text stream one byte per transfer on i_text and reports on
// o_line the one-based number of every nonempty line that contains the
// configured pattern of up to sixteen bytes. A newline byte closes a line, a
// NUL byte ends the searched part of its line, and the line counter saturates.
// The pattern is loaded through the write port (i_cfg_we, i_cfg_index,
// i_cfg_data): index 0 holds bytes 0 to 7, index 1 bytes 8 to 15, index 2 the
// length. The user must make writes only while no byte is in flight; the unit
// itself does not enforce this. An accepted byte sits in the input register,
// moves through the core, and on a hit its line number is offered on o_line
// from the result register. One byte is taken in every cycle unless o_line
// stalls; the rate is set by the single shift-and step between the input and result registers.
// When the receiver stalls, the result register holds its line number and the
// input register keeps its byte until the result register frees up, so
// i_text.ready drops only while both registers are occupied.
// Synchronous reset clears the pattern, both registers and all line state;
// no clearing pass follows and a byte can be accepted at the next edge.
module line_substring_search_unit
    import lss_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    lss_text_if.sink               i_text,
    lss_line_if.source             o_line,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_bytes;
    logic [PATTERN_MAX-1:0]             pat_enable;
    logic [PATTERN_MAX-1:0]             pat_last;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [LINE_W-1:0] r_out_line;

    logic      out_free;
    logic      advance;
    t_line_res core_res;

    // The held byte moves through the core whenever the result register can take a result.
    assign out_free     = !r_out_valid || o_line.ready;
    assign advance      = r_in_valid && out_free;
    assign i_text.ready = !r_in_valid || advance;

    assign o_line.valid       = r_out_valid;
    assign o_line.line_number = r_out_line;

    lss_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pat_bytes (pat_bytes),
        .o_enable    (pat_enable),
        .o_last      (pat_last)
    );

    lss_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_pat_bytes (pat_bytes),
        .i_enable    (pat_enable),
        .i_last      (pat_last),
        .o_res       (core_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    // Result register: loaded on a hit, emptied when the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_res.hit) begin
            r_out_valid <= 1'b1;
        end else if (o_line.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_res.hit) begin
            r_out_line <= core_res.line_number;
        end
    end

    // A hit that moves through the core must show up in the result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && core_res.hit |=> r_out_valid && (r_out_line == $past(core_res.line_number)))
        else $error("hit was not captured in the result register");

    // A fresh result can only follow a newline byte leaving the input register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance) && ($past(r_in_byte) == NEWLINE_BYTE))
        else $error("result appeared without a newline");

    // An accepted byte must be held in the input register on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_text.valid && i_text.ready |=> r_in_valid && (r_in_byte == $past(i_text.text_byte)))
        else $error("accepted byte was not captured");

endmodule
